@@ design/chs_pkg.sv @@
// Package for the CHS / linear block converter.
// Holds the pipeline word type, stage counts and register codes.
// No dependencies.
package chs_pkg;

    localparam int DIV1_FIRST = 2;
    localparam int DIV1_LAST  = 33;
    localparam int DIV2_INIT  = 34;
    localparam int DIV2_FIRST = 35;
    localparam int DIV2_LAST  = 66;
    localparam int LAST_STAGE = 67;

    localparam logic REG_SPT   = 1'b0;
    localparam logic REG_HEADS = 1'b1;

    localparam logic ACT_CHS_TO_BLK = 1'b0;
    localparam logic ACT_BLK_TO_CHS = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        action;
        logic [9:0]  start_cyl;
        logic [7:0]  start_head;
        logic [5:0]  start_sect;
        logic [9:0]  end_cyl;
        logic [7:0]  end_head;
        logic [5:0]  end_sect;
        logic [30:0] start_block;
        logic [30:0] block_count;
        logic [5:0]  spt;
        logic [7:0]  hpc;
        logic [13:0] spc;
        logic [17:0] m1_s;
        logic [17:0] m1_e;
        logic [24:0] prod_s;
        logic [24:0] prod_e;
        logic [26:0] blk_s;
        logic [26:0] blk_e;
        logic [31:0] a0_cnt;
        logic        a0_bad;
        logic [31:0] end_blk;
        logic [13:0] rem1_s;
        logic [13:0] rem1_e;
        logic [31:0] nq1_s;
        logic [31:0] nq1_e;
        logic [31:0] q1_s;
        logic [31:0] q1_e;
        logic [31:0] r1_s;
        logic [31:0] r1_e;
        logic [5:0]  rem2_s;
        logic [5:0]  rem2_e;
        logic [31:0] nq2_s;
        logic [31:0] nq2_e;
        logic [31:0] o_start_cyl;
        logic [7:0]  o_start_head;
        logic [5:0]  o_start_sect;
        logic [31:0] o_end_cyl;
        logic [7:0]  o_end_head;
        logic [5:0]  o_end_sect;
        logic [31:0] o_start_block;
        logic [31:0] o_block_count;
        logic        o_bad;
    } stage_t;

endpackage

@@ design/chs_lba_converter_top.sv @@
// An accepted input word enters stage 0 and its result word leaves the last stage.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// The two divisions are restoring dividers, one quotient bit per stage.
// Reset is synchronous and active low; it clears all valid bits and loads
// the geometry registers with 63 sectors per track and 255 heads.
// Depends on chs_pkg.
module chs_lba_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [9:0]  s_start_cyl,
    input  logic [7:0]  s_start_head,
    input  logic [5:0]  s_start_sect,
    input  logic [9:0]  s_end_cyl,
    input  logic [7:0]  s_end_head,
    input  logic [5:0]  s_end_sect,
    input  logic [30:0] s_start_block,
    input  logic [30:0] s_block_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_start_cyl,
    output logic [7:0]  m_out_start_head,
    output logic [5:0]  m_out_start_sect,
    output logic [31:0] m_out_end_cyl,
    output logic [7:0]  m_out_end_head,
    output logic [5:0]  m_out_end_sect,
    output logic [31:0] m_out_start_block,
    output logic [31:0] m_out_block_count,
    output logic        m_bad_range
);

    logic [5:0] spt_reg;
    logic [7:0] hpc_reg;
    logic       advance;
    chs_pkg::stage_t stg_reg  [0:chs_pkg::LAST_STAGE];
    chs_pkg::stage_t stg_next [0:chs_pkg::LAST_STAGE];

    function automatic chs_pkg::stage_t stage_step(input int k, input chs_pkg::stage_t p,
                                                   input logic [5:0] spt,
                                                   input logic [7:0] hpc);
        chs_pkg::stage_t n;
        logic [14:0] t1s;
        logic [14:0] t1e;
        logic [6:0]  t2s;
        logic [6:0]  t2e;
        logic [26:0] dif;
        logic [31:0] q2s;
        logic [31:0] q2e;
        logic [31:0] r2s;
        logic [31:0] r2e;
        n = p;
        t1s = {p.rem1_s, p.nq1_s[31]};
        t1e = {p.rem1_e, p.nq1_e[31]};
        t2s = {p.rem2_s, p.nq2_s[31]};
        t2e = {p.rem2_e, p.nq2_e[31]};
        dif = p.blk_e - p.blk_s;
        q2s = (p.spt == 6'd0) ? 32'hFFFF_FFFF : p.nq2_s;
        q2e = (p.spt == 6'd0) ? 32'hFFFF_FFFF : p.nq2_e;
        r2s = (p.spt == 6'd0) ? p.r1_s : {26'd0, p.rem2_s};
        r2e = (p.spt == 6'd0) ? p.r1_e : {26'd0, p.rem2_e};
        if (k == 1) begin
            n.spt     = spt;
            n.hpc     = hpc;
            n.spc     = {8'd0, spt} * {6'd0, hpc};
            n.m1_s    = {8'd0, p.start_cyl} * {10'd0, hpc};
            n.m1_e    = {8'd0, p.end_cyl} * {10'd0, hpc};
            n.end_blk = {1'b0, p.start_block} + {1'b0, p.block_count} - 32'd1;
            n.nq1_s   = {1'b0, p.start_block};
            n.nq1_e   = {1'b0, p.start_block} + {1'b0, p.block_count} - 32'd1;
            n.rem1_s  = '0;
            n.rem1_e  = '0;
        end
        if (k == 2) begin
            n.prod_s = {7'd0, p.m1_s + {10'd0, p.start_head}} * {19'd0, p.spt};
            n.prod_e = {7'd0, p.m1_e + {10'd0, p.end_head}} * {19'd0, p.spt};
        end
        if (k == 3) begin
            n.blk_s = {2'b00, p.prod_s} + {21'd0, p.start_sect} - 27'd1;
            n.blk_e = {2'b00, p.prod_e} + {21'd0, p.end_sect} - 27'd1;
        end
        if (k == 4) begin
            n.a0_cnt = {{5{dif[26]}}, dif} + 32'd1;
            n.a0_bad = $signed(p.blk_s) > $signed(p.blk_e);
        end
        if (k inside {[chs_pkg::DIV1_FIRST:chs_pkg::DIV1_LAST]}) begin
            if (t1s >= {1'b0, p.spc}) begin
                n.rem1_s = 14'(t1s - {1'b0, p.spc});
                n.nq1_s  = {p.nq1_s[30:0], 1'b1};
            end else begin
                n.rem1_s = t1s[13:0];
                n.nq1_s  = {p.nq1_s[30:0], 1'b0};
            end
            if (t1e >= {1'b0, p.spc}) begin
                n.rem1_e = 14'(t1e - {1'b0, p.spc});
                n.nq1_e  = {p.nq1_e[30:0], 1'b1};
            end else begin
                n.rem1_e = t1e[13:0];
                n.nq1_e  = {p.nq1_e[30:0], 1'b0};
            end
        end
        if (k == chs_pkg::DIV2_INIT) begin
            if (p.spc == 14'd0) begin
                n.q1_s = 32'hFFFF_FFFF;
                n.q1_e = 32'hFFFF_FFFF;
                n.r1_s = {1'b0, p.start_block};
                n.r1_e = p.end_blk;
            end else begin
                n.q1_s = p.nq1_s;
                n.q1_e = p.nq1_e;
                n.r1_s = {18'd0, p.rem1_s};
                n.r1_e = {18'd0, p.rem1_e};
            end
            n.nq2_s  = n.r1_s;
            n.nq2_e  = n.r1_e;
            n.rem2_s = '0;
            n.rem2_e = '0;
        end
        if (k inside {[chs_pkg::DIV2_FIRST:chs_pkg::DIV2_LAST]}) begin
            if (t2s >= {1'b0, p.spt}) begin
                n.rem2_s = 6'(t2s - {1'b0, p.spt});
                n.nq2_s  = {p.nq2_s[30:0], 1'b1};
            end else begin
                n.rem2_s = t2s[5:0];
                n.nq2_s  = {p.nq2_s[30:0], 1'b0};
            end
            if (t2e >= {1'b0, p.spt}) begin
                n.rem2_e = 6'(t2e - {1'b0, p.spt});
                n.nq2_e  = {p.nq2_e[30:0], 1'b1};
            end else begin
                n.rem2_e = t2e[5:0];
                n.nq2_e  = {p.nq2_e[30:0], 1'b0};
            end
        end
        if (k == chs_pkg::LAST_STAGE) begin
            if (p.action == chs_pkg::ACT_CHS_TO_BLK) begin
                n.o_start_cyl   = {22'd0, p.start_cyl};
                n.o_start_head  = p.start_head;
                n.o_start_sect  = p.start_sect;
                n.o_end_cyl     = {22'd0, p.end_cyl};
                n.o_end_head    = p.end_head;
                n.o_end_sect    = p.end_sect;
                n.o_start_block = {{5{p.blk_s[26]}}, p.blk_s};
                n.o_block_count = p.a0_cnt;
                n.o_bad         = p.a0_bad;
            end else begin
                n.o_start_cyl   = p.q1_s;
                n.o_start_head  = q2s[7:0];
                n.o_start_sect  = r2s[5:0] + 6'd1;
                n.o_end_cyl     = p.q1_e;
                n.o_end_head    = q2e[7:0];
                n.o_end_sect    = r2e[5:0] + 6'd1;
                n.o_start_block = {1'b0, p.start_block};
                n.o_block_count = {1'b0, p.block_count};
                n.o_bad         = (p.block_count == 31'd0);
            end
        end
        return n;
    endfunction

    assign advance   = !stg_reg[chs_pkg::LAST_STAGE].valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        stg_next[0]             = stg_reg[0];
        stg_next[0].valid       = s_valid;
        stg_next[0].action      = s_action;
        stg_next[0].start_cyl   = s_start_cyl;
        stg_next[0].start_head  = s_start_head;
        stg_next[0].start_sect  = s_start_sect;
        stg_next[0].end_cyl     = s_end_cyl;
        stg_next[0].end_head    = s_end_head;
        stg_next[0].end_sect    = s_end_sect;
        stg_next[0].start_block = s_start_block;
        stg_next[0].block_count = s_block_count;
        for (int k = 1; k <= chs_pkg::LAST_STAGE; k++) begin
            stg_next[k] = stage_step(k, stg_reg[k-1], spt_reg, hpc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg <= 6'd63;
            hpc_reg <= 8'd255;
        end else if (cfg_valid) begin
            case (cfg_addr)
                chs_pkg::REG_SPT:   spt_reg <= cfg_data[5:0];
                chs_pkg::REG_HEADS: hpc_reg <= cfg_data;
                default:            spt_reg <= spt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= chs_pkg::LAST_STAGE; k++) begin
                stg_reg[k].valid <= 1'b0;
            end
        end else if (advance) begin
            for (int k = 0; k <= chs_pkg::LAST_STAGE; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign m_valid           = stg_reg[chs_pkg::LAST_STAGE].valid;
    assign m_out_start_cyl   = stg_reg[chs_pkg::LAST_STAGE].o_start_cyl;
    assign m_out_start_head  = stg_reg[chs_pkg::LAST_STAGE].o_start_head;
    assign m_out_start_sect  = stg_reg[chs_pkg::LAST_STAGE].o_start_sect;
    assign m_out_end_cyl     = stg_reg[chs_pkg::LAST_STAGE].o_end_cyl;
    assign m_out_end_head    = stg_reg[chs_pkg::LAST_STAGE].o_end_head;
    assign m_out_end_sect    = stg_reg[chs_pkg::LAST_STAGE].o_end_sect;
    assign m_out_start_block = stg_reg[chs_pkg::LAST_STAGE].o_start_block;
    assign m_out_block_count = stg_reg[chs_pkg::LAST_STAGE].o_block_count;
    assign m_bad_range       = stg_reg[chs_pkg::LAST_STAGE].o_bad;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result word valid right after reset.");
    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Input taken while the pipeline is stalled.");
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> stg_reg[0].valid)
        else $error("Accepted word missing from the first stage.");

endmodule
